// ===== rtl/core/bts_pkg.sv =====
// Package for the bilinear texture sampler: codes, configuration and sample
// descriptor types, field widths and reset values. No dependencies.
package bts_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int SIZE_W    = 10;  // width_in_use / height_in_use
  localparam int COLOR_W   = 24;  // packed RGB888, red high
  localparam int CH_W      = 8;
  localparam int FRAC_W    = 16;
  localparam int COORD_W   = 32;  // signed Q16.16
  localparam int TEX_IDX_W = 9;   // texel_col / texel_row of a write
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [SIZE_W-1:0]  RST_WIDTH   = 10'd512;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT  = 10'd512;
  localparam logic               RST_PRESENT = 1'b1;
  localparam logic [COLOR_W-1:0] RST_COLOR   = 24'h000000;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_PRESENT = 2'd2,
    REG_COLOR   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_BILINEAR = 2'd1,
    ACT_NEAREST  = 2'd2
  } action_e;

  // What an item does once it is inside the pipeline
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_BILIN = 2'd1,
    KIND_NEAR  = 2'd2,
    KIND_CONST = 2'd3
  } kind_e;

  // Sizes already clamped to 1..MAX
  typedef struct packed {
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic               present;
    logic [COLOR_W-1:0] color;
  } cfg_t;

  // Sample descriptor travelling alongside the store read
  typedef struct packed {
    kind_e              kind;
    logic [FRAC_W-1:0]  frac_a;
    logic [FRAC_W-1:0]  frac_b;
    logic               near_ok;
    logic [COLOR_W-1:0] color;
  } smp_t;

endpackage

// ===== rtl/core/bts_cfg_regs.sv =====
// APB-style configuration registers of the texture sampler.
// Depends on bts_pkg for register codes, reset values and cfg_t.
module bts_cfg_regs import bts_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [SIZE_W-1:0]  width_q, width_d;
  logic [SIZE_W-1:0]  height_q, height_d;
  logic               present_q, present_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    present_d = present_q;
    color_d   = color_q;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH:   width_d   = pwdata[SIZE_W-1:0];
        REG_HEIGHT:  height_d  = pwdata[SIZE_W-1:0];
        REG_PRESENT: present_d = pwdata[0];
        REG_COLOR:   color_d   = pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= RST_WIDTH;
      height_q  <= RST_HEIGHT;
      present_q <= RST_PRESENT;
      color_q   <= RST_COLOR;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      present_q <= present_d;
      color_q   <= color_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:   prdata = PDATA_W'(width_q);
      REG_HEIGHT:  prdata = PDATA_W'(height_q);
      REG_PRESENT: prdata = PDATA_W'(present_q);
      REG_COLOR:   prdata = PDATA_W'(color_q);
      default:     prdata = '0;
    endcase
  end

  // zero acts as one, anything above the store size as the store size
  always_comb begin
    cfg_o.present = present_q;
    cfg_o.color   = color_q;
    if (width_q == '0)                  cfg_o.width = SIZE_W'(1);
    else if (32'(width_q) > MAX_WIDTH)  cfg_o.width = SIZE_W'(MAX_WIDTH);
    else                                cfg_o.width = width_q;
    if (height_q == '0)                 cfg_o.height = SIZE_W'(1);
    else if (32'(height_q) > MAX_HEIGHT) cfg_o.height = SIZE_W'(MAX_HEIGHT);
    else                                cfg_o.height = height_q;
  end

endmodule

// ===== rtl/core/bts_coord_stage.sv =====
// Input stage: decodes the action, scales coordinates by (size-1) and forms
// the store addresses for writes and 2x2 reads. Depends on bts_pkg.
module bts_coord_stage import bts_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int AW         = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [COORD_W-1:0]   coord_u_i,
  input  logic [COORD_W-1:0]   coord_v_i,
  input  logic [TEX_IDX_W-1:0] texel_col_i,
  input  logic [TEX_IDX_W-1:0] texel_row_i,
  input  logic [COLOR_W-1:0]   write_rgb_i,
  input  logic                 adv_i,
  output logic                 smp_valid_o,
  output smp_t                 smp_o,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic [COLOR_W-1:0]   wr_data_o,
  output logic [AW-1:0]        rd_addr_a0_o,
  output logic [AW-1:0]        rd_addr_a1_o,
  output logic [AW-1:0]        rd_addr_b0_o,
  output logic [AW-1:0]        rd_addr_b1_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW = COORD_W + 1 + SIZE_W + 1;  // 44-bit scaled coordinate

  logic                 v_q, v_d;
  kind_e                kind_q, kind_d;
  logic signed [PW-1:0] pu_q, pu_d, pv_q, pv_d;
  logic [TEX_IDX_W-1:0] col_q, row_q;
  logic [COLOR_W-1:0]   rgb_q;
  logic                 wr_ok_q, wr_ok_d;
  logic                 act_ok;
  logic                 load;

  logic signed [COORD_W:0]  op_u, op_v;
  logic signed [SIZE_W:0]   mu, mv;

  // accept side
  assign in_ready_o = !v_q || adv_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    act_ok = 1'b1;
    unique case (action_i)
      ACT_WRITE:    kind_d = KIND_WRITE;
      ACT_BILINEAR: kind_d = cfg_i.present ? KIND_BILIN : KIND_CONST;
      ACT_NEAREST:  kind_d = cfg_i.present ? KIND_NEAR : KIND_CONST;
      default: begin
        kind_d = KIND_WRITE;
        act_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    // bilinear takes the wrapped fraction, nearest the full signed coordinate
    if (action_i == ACT_NEAREST) begin
      op_u = {coord_u_i[COORD_W-1], coord_u_i};
      op_v = {coord_v_i[COORD_W-1], coord_v_i};
    end else begin
      op_u = {{(COORD_W+1-FRAC_W){1'b0}}, coord_u_i[FRAC_W-1:0]};
      op_v = {{(COORD_W+1-FRAC_W){1'b0}}, coord_v_i[FRAC_W-1:0]};
    end
    mu   = {1'b0, cfg_i.width - SIZE_W'(1)};
    mv   = {1'b0, cfg_i.height - SIZE_W'(1)};
    pu_d = op_u * mu;
    pv_d = op_v * mv;
    wr_ok_d = (32'(texel_col_i) < MAX_WIDTH) && (32'(texel_row_i) < MAX_HEIGHT);
  end

  always_comb begin
    if (in_ready_o) v_d = load && act_ok;
    else            v_d = v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else         v_q <= v_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      pu_q    <= pu_d;
      pv_q    <= pv_d;
      col_q   <= texel_col_i;
      row_q   <= texel_row_i;
      rgb_q   <= write_rgb_i;
      wr_ok_q <= wr_ok_d;
    end
  end

  // address stage
  logic [CW-1:0] bx0, bx1, nx, col0, col1;
  logic [RW-1:0] by0, by1, ny, row0, row1;
  logic          ok_u, ok_v, near_ok;
  logic          is_bilin;

  always_comb begin
    bx0 = pu_q[FRAC_W +: CW];
    by0 = pv_q[FRAC_W +: RW];
    // x+1 and y+1 wrap modulo the size
    if (13'(bx0) + 13'd1 == 13'(cfg_i.width)) bx1 = '0;
    else                                      bx1 = CW'(13'(bx0) + 13'd1);
    if (13'(by0) + 13'd1 == 13'(cfg_i.height)) by1 = '0;
    else                                       by1 = RW'(13'(by0) + 13'd1);

    // truncation toward zero: small negatives land on index 0
    if (pu_q[PW-1]) ok_u = (&pu_q[PW-2:FRAC_W]) && (|pu_q[FRAC_W-1:0]);
    else            ok_u = pu_q[PW-2:FRAC_W] < (PW-1-FRAC_W)'(cfg_i.width);
    if (pv_q[PW-1]) ok_v = (&pv_q[PW-2:FRAC_W]) && (|pv_q[FRAC_W-1:0]);
    else            ok_v = pv_q[PW-2:FRAC_W] < (PW-1-FRAC_W)'(cfg_i.height);
    near_ok = ok_u && ok_v;

    nx = (pu_q[PW-1] || !near_ok) ? '0 : pu_q[FRAC_W +: CW];
    ny = (pv_q[PW-1] || !near_ok) ? '0 : pv_q[FRAC_W +: RW];

    is_bilin = (kind_q == KIND_BILIN);
    col0 = is_bilin ? bx0 : nx;
    col1 = is_bilin ? bx1 : nx;
    row0 = is_bilin ? by0 : ny;
    row1 = is_bilin ? by1 : ny;

    rd_addr_a0_o = AW'(32'(row0) * MAX_WIDTH + 32'(col0));
    rd_addr_a1_o = AW'(32'(row0) * MAX_WIDTH + 32'(col1));
    rd_addr_b0_o = AW'(32'(row1) * MAX_WIDTH + 32'(col0));
    rd_addr_b1_o = AW'(32'(row1) * MAX_WIDTH + 32'(col1));
    wr_addr_o    = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));
  end

  assign wr_data_o   = rgb_q;
  assign wr_en_o     = v_q && (kind_q == KIND_WRITE) && wr_ok_q && adv_i;
  assign smp_valid_o = v_q && (kind_q != KIND_WRITE);

  always_comb begin
    smp_o.kind    = kind_q;
    smp_o.frac_a  = pu_q[FRAC_W-1:0];
    smp_o.frac_b  = pv_q[FRAC_W-1:0];
    smp_o.near_ok = near_ok;
    smp_o.color   = cfg_i.color;
  end

endmodule

// ===== rtl/core/bts_texel_mem.sv =====
// Texel store kept as two identical copies, each with one write port and two
// registered read ports, four reads a cycle while re_i is high. Uses bts_pkg.
module bts_texel_mem import bts_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int AW    = 18
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [COLOR_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_a0_i,
  input  logic [AW-1:0]      raddr_a1_i,
  input  logic [AW-1:0]      raddr_b0_i,
  input  logic [AW-1:0]      raddr_b1_i,
  output logic [COLOR_W-1:0] rdata_a0_o,
  output logic [COLOR_W-1:0] rdata_a1_o,
  output logic [COLOR_W-1:0] rdata_b0_o,
  output logic [COLOR_W-1:0] rdata_b1_o
);

  logic [COLOR_W-1:0] mem_a [DEPTH];
  logic [COLOR_W-1:0] mem_b [DEPTH];

  // copy A serves row y0, copy B row y1
  always_ff @(posedge clk_i) begin
    if (we_i) mem_a[waddr_i] <= wdata_i;
    if (re_i) begin
      rdata_a0_o <= mem_a[raddr_a0_i];
      rdata_a1_o <= mem_a[raddr_a1_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem_b[waddr_i] <= wdata_i;
    if (re_i) begin
      rdata_b0_o <= mem_b[raddr_b0_i];
      rdata_b1_o <= mem_b[raddr_b1_i];
    end
  end

endmodule

// ===== rtl/core/bts_blend.sv =====
// Blend pipeline: horizontal then vertical weighted sums per channel,
// rounding, result select and the output register. Depends on bts_pkg.
module bts_blend import bts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               smp_valid_i,
  input  smp_t               smp_i,
  output logic               take_o,
  input  logic [COLOR_W-1:0] tex0_i,   // (x0, y0)
  input  logic [COLOR_W-1:0] tex1_i,   // (x1, y0)
  input  logic [COLOR_W-1:0] tex2_i,   // (x0, y1)
  input  logic [COLOR_W-1:0] tex3_i,   // (x1, y1)
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CH_W-1:0]    red_o,
  output logic [CH_W-1:0]    green_o,
  output logic [CH_W-1:0]    blue_o,
  output logic               in_range_o
);

  localparam int HW = 24;  // 65536*255 fits
  localparam int VW = 40;  // 2^32*255 + 2^31 fits

  // stage 2: descriptor next to the store read data
  logic v2_q, v2_d;
  smp_t s2_q;
  // stage 3: horizontal sums
  logic               v3_q, v3_d;
  logic [HW-1:0]      h0_q [3];
  logic [HW-1:0]      h1_q [3];
  logic [HW-1:0]      h0_d [3];
  logic [HW-1:0]      h1_d [3];
  logic [FRAC_W-1:0]  b3_q;
  logic               bilin3_q;
  logic [COLOR_W-1:0] direct3_q, direct_d;
  logic               inr3_q, inr_d;
  // stage 4: output register
  logic               ov_q, ov_d;
  logic [COLOR_W-1:0] rgb_q, rgb_d;
  logic               inr_q;

  logic en3, en4;
  logic [FRAC_W:0]    wa_n, wb_n;
  logic [VW-1:0]      acc [3];
  logic [COLOR_W-1:0] blend_rgb;

  assign en4    = !ov_q || out_ready_i;
  assign en3    = !v3_q || en4;
  assign take_o = !v2_q || en3;

  assign v2_d = take_o ? smp_valid_i : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;
  assign ov_d = en4 ? v3_q : ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      v2_q <= v2_d;
      v3_q <= v3_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) s2_q <= smp_i;
  end

  // horizontal: (1-a)*left + a*right, kept exact
  always_comb begin
    wa_n = 17'h10000 - {1'b0, s2_q.frac_a};
    for (int c = 0; c < 3; c++) begin
      h0_d[c] = HW'(25'(wa_n) * 25'(tex0_i[CH_W*c +: CH_W])
                  + 25'(s2_q.frac_a) * 25'(tex1_i[CH_W*c +: CH_W]));
      h1_d[c] = HW'(25'(wa_n) * 25'(tex2_i[CH_W*c +: CH_W])
                  + 25'(s2_q.frac_a) * 25'(tex3_i[CH_W*c +: CH_W]));
    end
    case (s2_q.kind)
      KIND_CONST: direct_d = s2_q.color;
      KIND_NEAR:  direct_d = s2_q.near_ok ? tex0_i : '0;
      default:    direct_d = '0;
    endcase
    inr_d = (s2_q.kind == KIND_NEAR) ? s2_q.near_ok : 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int c = 0; c < 3; c++) begin
        h0_q[c] <= h0_d[c];
        h1_q[c] <= h1_d[c];
      end
      b3_q      <= s2_q.frac_b;
      bilin3_q  <= (s2_q.kind == KIND_BILIN);
      direct3_q <= direct_d;
      inr3_q    <= inr_d;
    end
  end

  // vertical: (1-b)*top + b*bottom, round half up at 2^32
  always_comb begin
    wb_n = 17'h10000 - {1'b0, b3_q};
    for (int c = 0; c < 3; c++) begin
      acc[c] = VW'(wb_n) * VW'(h0_q[c]) + VW'(b3_q) * VW'(h1_q[c]) + 40'h0080000000;
      blend_rgb[CH_W*c +: CH_W] = acc[c][VW-1:32];
    end
    rgb_d = bilin3_q ? blend_rgb : direct3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      rgb_q <= rgb_d;
      inr_q <= inr3_q;
    end
  end

  assign out_valid_o = ov_q;
  assign red_o       = rgb_q[23:16];
  assign green_o     = rgb_q[15:8];
  assign blue_o      = rgb_q[7:0];
  assign in_range_o  = inr_q;

endmodule

// ===== rtl/core/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler.
// Depends on bts_pkg, bts_cfg_regs, bts_coord_stage, bts_texel_mem, bts_blend.
//
// Usage
//  - Input channel (in_valid_i/in_ready_o) carries one beat per item: a texel
//    write (action 0), a wrapped bilinear sample (1) or a bounded nearest
//    sample (2). Action 3 is taken and dropped. Writes give no result beat.
//  - Output channel (out_valid_o/out_ready_i) carries one beat per sample:
//    rounded RGB888 and in_range.
//  - Config registers sit on the APB-style port at byte addresses 0, 4, 8, 12
//    (width, height, image present, constant color); write them only while
//    the block is idle. pready is tied high.
//  - Throughput: one item per cycle, sustained while the receiver keeps
//    up. The texel store is held as two identical copies, each with two
//    read ports, so the four texels of a 2x2 footprint come out of one read.
//  - Pipeline: scale multiply, store read, horizontal blend, then vertical
//    blend and rounding into the output reg, each stage registered.
//  - A write reaches the store before any later sample reads it, since both
//    issue from the same pipeline stage in order.
//  - Reset clears the pipeline valid bits and loads the register defaults
//    (512 x 512, image present, black). The store is not cleared: a texel
//    that was never written reads as garbage.
//  - Receiver stall: the output register holds its beat; the stages behind
//    it keep filling, and in_ready_o drops only once all of them are full.
module bilinear_texture_sampler import bts_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB-style configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic signed [COORD_W-1:0] coord_u_i,
  input  logic signed [COORD_W-1:0] coord_v_i,
  input  logic [TEX_IDX_W-1:0] texel_col_i,
  input  logic [TEX_IDX_W-1:0] texel_row_i,
  input  logic [CH_W-1:0]      write_red_i,
  input  logic [CH_W-1:0]      write_green_i,
  input  logic [CH_W-1:0]      write_blue_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CH_W-1:0]      red_o,
  output logic [CH_W-1:0]      green_o,
  output logic [CH_W-1:0]      blue_o,
  output logic                 in_range_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t               cfg;
  smp_t               smp;
  logic               smp_valid;
  logic               take;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COLOR_W-1:0] wr_data;
  logic [AW-1:0]      ra_a0, ra_a1, ra_b0, ra_b1;
  logic [COLOR_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1;

  bts_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  bts_coord_stage #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .coord_u_i   (coord_u_i),
    .coord_v_i   (coord_v_i),
    .texel_col_i (texel_col_i),
    .texel_row_i (texel_row_i),
    .write_rgb_i ({write_red_i, write_green_i, write_blue_i}),
    .adv_i       (take),
    .smp_valid_o (smp_valid),
    .smp_o       (smp),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_a0_o(ra_a0),
    .rd_addr_a1_o(ra_a1),
    .rd_addr_b0_o(ra_b0),
    .rd_addr_b1_o(ra_b1)
  );

  // read data is registered only when stage 2 advances, so it holds on stall
  bts_texel_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .re_i      (take),
    .raddr_a0_i(ra_a0),
    .raddr_a1_i(ra_a1),
    .raddr_b0_i(ra_b0),
    .raddr_b1_i(ra_b1),
    .rdata_a0_o(rd_a0),
    .rdata_a1_o(rd_a1),
    .rdata_b0_o(rd_b0),
    .rdata_b1_o(rd_b1)
  );

  bts_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_valid_i(smp_valid),
    .smp_i      (smp),
    .take_o     (take),
    .tex0_i     (rd_a0),
    .tex1_i     (rd_a1),
    .tex2_i     (rd_b0),
    .tex3_i     (rd_b1),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .in_range_o (in_range_o)
  );

endmodule

// ===== rtl/core/bts_checker.sv =====
// Port-level checker for the texture sampler, bound to the top level.
// Depends on bilinear_texture_sampler port names and bts_pkg widths.
module bts_checker import bts_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [CH_W-1:0] red_o,
  input logic [CH_W-1:0] green_o,
  input logic [CH_W-1:0] blue_o,
  input logic            in_range_o
);

  // a result beat waits for the receiver
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({red_o, green_o, blue_o, in_range_o}))
    else $error("stalled result beat changed");

  // input side only backs up behind a held result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with a free output");

  // a sample outside the texture comes back black
  a_out_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> (red_o == '0) && (green_o == '0) && (blue_o == '0))
    else $error("out-of-range sample is not black");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .red_o      (red_o),
  .green_o    (green_o),
  .blue_o     (blue_o),
  .in_range_o (in_range_o)
);

// ===== test/tb_top.sv =====
// Testbench for bilinear_texture_sampler: texel writes, bilinear and nearest samples
// under several register settings, with every result beat checked against a predictor.
// Depends on bts_pkg and the sampler RTL.
`timescale 1ns / 1ps

module tb_top;
  import bts_pkg::*;

  localparam int STORE_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either channel
  localparam int LONG_HOLD    = 300;   // receiver back-pressure stretch
  localparam int DRAIN_CYCLES = 8;     // pipeline is 4 deep; writes leave no beat
  localparam int MAX_REPORTS  = 10;

  // action code the block takes and drops
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]           action;
    logic [COORD_W-1:0]   u;
    logic [COORD_W-1:0]   v;
    logic [TEX_IDX_W-1:0] col;
    logic [TEX_IDX_W-1:0] row;
    logic [CH_W-1:0]      r;
    logic [CH_W-1:0]      g;
    logic [CH_W-1:0]      b;
  } tex_item_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            in_range;
  } sample_t;

  // ---------------------------------------------------------------- DUT ports
  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [PADDR_W-1:0]          paddr         = '0;
  logic [PDATA_W-1:0]          pwdata        = '0;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  action_i      = '0;
  logic signed [COORD_W-1:0]   coord_u_i     = '0;
  logic signed [COORD_W-1:0]   coord_v_i     = '0;
  logic [TEX_IDX_W-1:0]        texel_col_i   = '0;
  logic [TEX_IDX_W-1:0]        texel_row_i   = '0;
  logic [CH_W-1:0]             write_red_i   = '0;
  logic [CH_W-1:0]             write_green_i = '0;
  logic [CH_W-1:0]             write_blue_i  = '0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic [CH_W-1:0]             red_o;
  logic [CH_W-1:0]             green_o;
  logic [CH_W-1:0]             blue_o;
  logic                        in_range_o;

  bilinear_texture_sampler dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .action_i, .coord_u_i, .coord_v_i,
    .texel_col_i, .texel_row_i, .write_red_i, .write_green_i, .write_blue_i,
    .out_valid_o, .out_ready_i, .red_o, .green_o, .blue_o, .in_range_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ------------------------------------------------------ predictor state
  // Register shadow, raw as written; the size clamp is applied on use.
  logic [SIZE_W-1:0]  cfg_width   = RST_WIDTH;
  logic [SIZE_W-1:0]  cfg_height  = RST_HEIGHT;
  logic               cfg_present = RST_PRESENT;
  logic [COLOR_W-1:0] cfg_color   = RST_COLOR;

  logic [COLOR_W-1:0] model_texels [STORE_DEPTH];  // updated on accepted writes
  bit                 texel_loaded [STORE_DEPTH];  // set when a write is queued

  tex_item_t items_to_send[$];
  sample_t   expected_samples[$];

  // handshake bookkeeping: written at posedge, read at negedge
  bit in_took, out_took;
  bit no_gaps, hold_req, hold_done;
  int send_wait, recv_wait, hold_left;
  int quiet_cycles, mismatches, items_queued, settings_run;
  int beats_in, writes_seen, bilinear_seen, nearest_seen, ignored_seen, results_seen;

  function automatic int texel_addr(longint x, longint y);
    return int'(y) * DEF_MAX_WIDTH + int'(x);
  endfunction

  // 0 acts as 1, anything above the store size acts as the store size
  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] s, int unsigned lim);
    if (s == 0) return 1;
    if (s > lim) return lim;
    return s;
  endfunction

  // (coord * (dim-1)) / 2^16, truncated toward zero
  function automatic longint near_index(logic [COORD_W-1:0] c, int unsigned dim);
    longint p;
    p = longint'($signed(c)) * longint'(dim - 1);
    if (p >= 0) return p >>> FRAC_W;
    return -((-p) >>> FRAC_W);
  endfunction

  function automatic void predict_texture_item(tex_item_t it);
    int unsigned        w, h, su, sv, x0, y0, x1, y1;
    longint unsigned    a, b, acc;
    longint unsigned    wt [4];
    logic [COLOR_W-1:0] t [4];
    logic [COLOR_W-1:0] rgb;
    longint             ix, iy;
    int                 sh, k;
    sample_t            res;
    w = clamp_dim(cfg_width, DEF_MAX_WIDTH);
    h = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
    if (it.action == ACT_WRITE) begin
      model_texels[texel_addr(it.col, it.row)] = {it.r, it.g, it.b};
      return;
    end
    if (it.action == ACT_UNUSED) return;
    res.in_range = 1'b1;
    if (!cfg_present) begin
      rgb = cfg_color;
    end else if (it.action == ACT_BILINEAR) begin
      // fraction times (size-1): integer part indexes, low 16 bits weight
      su = it.u[FRAC_W-1:0] * (w - 1);
      sv = it.v[FRAC_W-1:0] * (h - 1);
      x0 = su >> FRAC_W;
      y0 = sv >> FRAC_W;
      a  = su & 32'hFFFF;
      b  = sv & 32'hFFFF;
      x1 = (x0 + 1) % w;
      y1 = (y0 + 1) % h;
      t[0] = model_texels[texel_addr(x0, y0)];
      t[1] = model_texels[texel_addr(x1, y0)];
      t[2] = model_texels[texel_addr(x0, y1)];
      t[3] = model_texels[texel_addr(x1, y1)];
      wt[0] = (65536 - a) * (65536 - b);
      wt[1] = a * (65536 - b);
      wt[2] = (65536 - a) * b;
      wt[3] = a * b;
      rgb = '0;
      for (sh = 2 * CH_W; sh >= 0; sh -= CH_W) begin
        acc = 0;
        for (k = 0; k < 4; k++) acc += wt[k] * longint'((t[k] >> sh) & 24'hFF);
        acc = (acc + 64'h8000_0000) >> 32;  // round half up
        if (acc > 255) acc = 255;
        rgb[sh +: CH_W] = acc[CH_W-1:0];
      end
    end else begin
      ix = near_index(it.u, w);
      iy = near_index(it.v, h);
      if (ix >= 0 && ix < longint'(w) && iy >= 0 && iy < longint'(h)) begin
        rgb = model_texels[texel_addr(ix, iy)];
      end else begin
        rgb = '0;
        res.in_range = 1'b0;
      end
    end
    {res.r, res.g, res.b} = rgb;
    expected_samples.push_back(res);
  endfunction

  // ------------------------------------------------------ item generation
  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void queue_item(tex_item_t it);
    items_to_send.push_back(it);
    if (it.action != ACT_UNUSED) items_queued++;
    if (it.action == ACT_WRITE) texel_loaded[texel_addr(it.col, it.row)] = 1'b1;
  endfunction

  // fields the action does not use carry random values anyway
  function automatic tex_item_t random_item(logic [1:0] act);
    tex_item_t it;
    it.action = act;
    it.u = $urandom();
    it.v = $urandom();
    it.col = $urandom();
    it.row = $urandom();
    {it.r, it.g, it.b} = $urandom();
    return it;
  endfunction

  function automatic void queue_write(int unsigned x, int unsigned y, logic [COLOR_W-1:0] rgb);
    tex_item_t it;
    it = random_item(ACT_WRITE);
    it.col = x;
    it.row = y;
    {it.r, it.g, it.b} = rgb;
    queue_item(it);
  endfunction

  function automatic void load_texel(int unsigned x, int unsigned y);
    if (!texel_loaded[texel_addr(x, y)]) queue_write(x, y, $urandom());
  endfunction

  // The block may fetch the whole 2x2 neighborhood, so all four get loaded.
  function automatic void load_footprint(int unsigned x, int unsigned y,
                                         int unsigned w, int unsigned h);
    load_texel(x, y);
    load_texel((x + 1) % w, y);
    load_texel(x, (y + 1) % h);
    load_texel((x + 1) % w, (y + 1) % h);
  endfunction

  // Queue a sample, preceded by writes for any texel it would read unloaded.
  function automatic void queue_sample(logic [1:0] act, logic [COORD_W-1:0] u,
                                       logic [COORD_W-1:0] v);
    tex_item_t   it;
    int unsigned w, h;
    longint      ix, iy;
    w = clamp_dim(cfg_width, DEF_MAX_WIDTH);
    h = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
    if (cfg_present) begin
      if (act == ACT_BILINEAR) begin
        load_footprint((u[FRAC_W-1:0] * (w - 1)) >> FRAC_W,
                       (v[FRAC_W-1:0] * (h - 1)) >> FRAC_W, w, h);
      end else begin
        ix = near_index(u, w);
        iy = near_index(v, h);
        if (ix >= 0 && ix < longint'(w) && iy >= 0 && iy < longint'(h))
          load_footprint(ix, iy, w, h);
      end
    end
    it = random_item(act);
    it.u = u;
    it.v = v;
    queue_item(it);
  endfunction

  // Nearest coordinates: mostly inside [0, 1.0], some just outside either end, some fully random.
  function automatic logic [COORD_W-1:0] pick_near_coord();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return -$urandom_range(1, 32'hFFFF);
      2:       return 32'h1_0000 + $urandom_range(0, 32'h800);
      default: return $urandom_range(0, 32'h1_0000);
    endcase
  endfunction

  // ------------------------------------------------------ config port
  task automatic apb_write(input reg_idx_e idx, input logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);  // register took the value at the edge just passed
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH:   cfg_width   = data[SIZE_W-1:0];
      REG_HEIGHT:  cfg_height  = data[SIZE_W-1:0];
      REG_PRESENT: cfg_present = data[0];
      REG_COLOR:   cfg_color   = data[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic present, input logic [COLOR_W-1:0] color);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_PRESENT, present);
    apb_write(REG_COLOR, color);
    settings_run++;
  endtask

  // Queue drained, every result back, then DRAIN_CYCLES more for a trailing write.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid_i || expected_samples.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic present, input logic [COLOR_W-1:0] color,
                           input int quota, input bit steady, input bit long_hold);
    int pick;
    set_config(w, h, present, color);
    @(posedge clk_i);
    no_gaps = steady;
    if (long_hold) hold_req = 1'b1;
    items_queued = 0;
    while (items_queued < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       queue_item(random_item(ACT_WRITE));
      else if (pick < 11) queue_item(random_item(ACT_UNUSED));
      else if (pick < 55) queue_sample(ACT_BILINEAR, $urandom(), $urandom());
      else                queue_sample(ACT_NEAREST, pick_near_coord(), pick_near_coord());
    end
    wait_idle();
  endtask

  // ------------------------------------------------------ sender
  // A new item goes out only once the one on the port was taken (or none was up).
  always @(negedge clk_i) begin
    tex_item_t it;
    if (!in_valid_i || in_took) begin
      if (send_wait != 0) begin
        in_valid_i <= 1'b0;
        send_wait--;
      end else if (items_to_send.size() != 0) begin
        it = items_to_send.pop_front();
        action_i      <= it.action;
        coord_u_i     <= it.u;
        coord_v_i     <= it.v;
        texel_col_i   <= it.col;
        texel_row_i   <= it.row;
        write_red_i   <= it.r;
        write_green_i <= it.g;
        write_blue_i  <= it.b;
        in_valid_i    <= 1'b1;
        send_wait     = draw_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------ receiver
  // Random stall after each result beat (none while no_gaps is set); one long
  // hold on request so the pipeline fills and in_ready_o has to drop.
  always @(negedge clk_i) begin
    if (out_took) recv_wait = draw_gap();
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (recv_wait != 0) begin
      out_ready_i <= 1'b0;
      recv_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ------------------------------------------------------ monitor
  function automatic void report_mismatch(string what, sample_t want, sample_t got);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s: expected rgb %02h%02h%02h in_range %0b, got %02h%02h%02h in_range %0b",
               $realtime, what, want.r, want.g, want.b, want.in_range,
               got.r, got.g, got.b, got.in_range);
    mismatches++;
  endfunction

  always @(posedge clk_i) begin
    sample_t got;
    sample_t want;
    in_took  = rst_ni && in_valid_i && in_ready_o;
    out_took = rst_ni && out_valid_o && out_ready_i;

    // result beats: compare with the oldest expectation
    if (out_took) begin
      got = '{red_o, green_o, blue_o, in_range_o};
      results_seen++;
      if (expected_samples.size() == 0) begin
        report_mismatch("result beat with nothing expected", '0, got);
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) report_mismatch("sample mismatch", want, got);
      end
    end

    // input beats: run the predictor in acceptance order
    if (in_took) begin
      beats_in++;
      case (action_i)
        ACT_WRITE:    writes_seen++;
        ACT_BILINEAR: bilinear_seen++;
        ACT_NEAREST:  nearest_seen++;
        default:      ignored_seen++;
      endcase
      predict_texture_item('{action_i, coord_u_i, coord_v_i, texel_col_i, texel_row_i,
                             write_red_i, write_green_i, write_blue_i});
    end

    // watchdog: a hang on either channel ends the run
    if (in_took || out_took) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ------------------------------------------------------ stimulus
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset values: 512 x 512 with the image present; far corner and largest fraction.
    queue_sample(ACT_NEAREST, 32'h0001_0000, 32'h0001_0000);
    queue_sample(ACT_BILINEAR, 32'h0000_FFFF, 32'h0000_FFFF);
    wait_idle();

    // Directed 2x2 texture with extreme channel values.
    set_config(10'd2, 10'd2, 1'b1, 24'h3C_A5_5A);
    @(posedge clk_i);
    queue_write(0, 0, 24'h00_00_00);
    queue_write(1, 0, 24'hFF_FF_FF);
    queue_write(0, 1, 24'hFF_00_80);
    queue_write(1, 1, 24'h12_34_56);
    queue_write(511, 511, 24'hFF_FF_FF);              // highest store address
    queue_sample(ACT_BILINEAR, 32'h0000_0000, 32'h0000_0000);
    queue_sample(ACT_BILINEAR, 32'h0000_FFFF, 32'h0000_FFFF);
    queue_sample(ACT_BILINEAR, 32'h0000_8000, 32'h0000_8000);  // exact half weights
    queue_sample(ACT_BILINEAR, 32'hFFFF_8000, 32'h7FFF_4000);  // integer part dropped
    queue_sample(ACT_NEAREST, 32'h0000_0000, 32'h0000_0000);
    queue_sample(ACT_NEAREST, 32'h0001_0000, 32'h0001_0000);   // 1.0 lands on last texel
    queue_sample(ACT_NEAREST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // tiny negative -> index 0
    queue_sample(ACT_NEAREST, 32'h7FFF_FFFF, 32'h0000_0000);   // far right, out of range
    queue_sample(ACT_NEAREST, 32'h8000_0000, 32'h0000_0000);   // most negative
    queue_sample(ACT_NEAREST, 32'h0002_0000, 32'h0000_0000);   // one past the edge
    queue_sample(ACT_NEAREST, 32'h0000_0000, 32'hFFFF_0000);   // -1.0, above the top
    queue_item(random_item(ACT_UNUSED));
    wait_idle();

    // No image: constant color for both kinds, even far outside.
    set_config(10'd2, 10'd2, 1'b0, 24'hFF_FF_FF);
    @(posedge clk_i);
    queue_sample(ACT_BILINEAR, $urandom(), $urandom());
    queue_sample(ACT_NEAREST, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();

    // Random phases. Single-texel sizes exercise the neighbor wrap; 0 and
    // 1023 exercise the size clamp. One phase runs the sender flat out while
    // the receiver holds off.
    run_phase(10'd1,    10'd1,    1'b1, $urandom(), 40, 1'b0, 1'b0);
    run_phase(10'd6,    10'd4,    1'b1, $urandom(), 50, 1'b1, 1'b1);
    run_phase(10'd0,    10'd5,    1'b1, $urandom(), 40, 1'b0, 1'b0);
    run_phase(10'd7,    10'd1,    1'b1, $urandom(), 40, 1'b1, 1'b0);
    run_phase(10'd1023, 10'd1023, 1'b1, $urandom(), 50, 1'b0, 1'b0);
    run_phase(10'd512,  10'd512,  1'b1, $urandom(), 50, 1'b1, 1'b0);
    run_phase(10'd16,   10'd9,    1'b1, $urandom(), 50, 1'b0, 1'b0);
    run_phase(10'd3,    10'd64,   1'b1, $urandom(), 45, 1'b1, 1'b0);
    run_phase($urandom_range(1, 40), $urandom_range(1, 40), 1'b1, $urandom(), 50,
              1'b0, 1'b0);
    run_phase(10'd300,  10'd2,    1'b1, $urandom(), 40, 1'b0, 1'b0);
    run_phase(10'd5,    10'd5,    1'b0, $urandom(), 30, 1'b0, 1'b0);
    run_phase(10'd0,    10'd1023, 1'b0, 24'hFF_FF_FF, 25, 1'b1, 1'b0);
    run_phase(10'd4,    10'd4,    1'b1, 24'h00_00_00, 40, 1'b0, 1'b0);

    $display("Sent %0d input beats: %0d texel writes, %0d bilinear, %0d nearest, %0d dropped,",
             beats_in, writes_seen, bilinear_seen, nearest_seen, ignored_seen);
    $display("across %0d register settings; %0d result beats compared, %0d mismatches.",
             settings_run, results_seen, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
